FILE: rtl/core/sks_pkg.sv
package sks_pkg;

  localparam int SAMPLE_BITS_DEF   = 12;
  localparam int COV_FRAC_BITS_DEF = 24;
  localparam int EST_FRAC          = 16;
  localparam int NOISE_W           = 24;
  localparam int DIGIT_W           = 8;
  localparam int APB_DATA_W        = 32;
  localparam int APB_ADDR_W        = 3;

  localparam logic [NOISE_W-1:0] PROCESS_NOISE_RST = NOISE_W'(1678);
  localparam logic [NOISE_W-1:0] MEASURE_NOISE_RST = NOISE_W'(83886);

  // register index, taken from paddr[2]
  localparam logic REG_PROCESS_NOISE = 1'b0;
  localparam logic REG_MEASURE_NOISE = 1'b1;

  // multiplier operand selection
  localparam logic MUL_GAIN_DIFF = 1'b0;
  localparam logic MUL_M_PP      = 1'b1;

  typedef struct packed {
    logic load;
    logic div_step;
    logic prep;
    logic mul_init;
    logic mul_sel;
    logic mul_step;
    logic upd_x;
    logic upd_p;
    logic out_load;
  } sks_cmd_t;

  typedef struct packed {
    logic div_last;
    logic mul_last;
  } sks_status_t;

endpackage

FILE: rtl/core/sks_regs.sv
module sks_regs
  import sks_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [NOISE_W-1:0]    process_noise,
  output logic [NOISE_W-1:0]    measure_noise
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise <= PROCESS_NOISE_RST;
      measure_noise <= MEASURE_NOISE_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_PROCESS_NOISE: process_noise <= pwdata[NOISE_W-1:0];
        REG_MEASURE_NOISE: measure_noise <= pwdata[NOISE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_PROCESS_NOISE: prdata = APB_DATA_W'(process_noise);
      REG_MEASURE_NOISE: prdata = APB_DATA_W'(measure_noise);
      default:           prdata = '0;
    endcase
  end

endmodule

FILE: rtl/core/sks_datapath.sv
module sks_datapath
  import sks_pkg::*;
#(
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
  parameter int COV_FRAC_BITS = COV_FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  sks_cmd_t               cmd,
  output sks_status_t            status,
  input  logic [NOISE_W-1:0]     process_noise,
  input  logic [NOISE_W-1:0]     measure_noise,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic [SAMPLE_BITS-1:0] smoothed
);

  localparam int EW   = SAMPLE_BITS + EST_FRAC;
  localparam int CF   = COV_FRAC_BITS;
  localparam int PW   = ((CF > NOISE_W) ? CF : NOISE_W) + 1;
  localparam int DW   = PW + 1;
  localparam int QW   = CF + 1;
  localparam int NDIG = (QW + DIGIT_W - 1) / DIGIT_W;
  localparam int GW   = NDIG * DIGIT_W;
  localparam int MW   = (EW > PW) ? EW : PW;
  localparam int AW   = MW + GW;
  localparam int CNTW = $clog2(QW);
  localparam int HW   = AW - CF;

  localparam logic [QW-1:0] ONE = QW'(1) << CF;

  logic [EW-1:0]   z;
  logic [EW-1:0]   est;
  logic [CF-1:0]   cov;
  logic [PW-1:0]   pp;
  logic [DW-1:0]   den;
  logic [DW-1:0]   rem;
  logic [QW-1:0]   quo;
  logic [QW-1:0]   mval;
  logic [QW-1:0]   gain;
  logic            x_ge;
  logic [EW-1:0]   diff;
  logic [GW-1:0]   dig;
  logic [MW-1:0]   mcand;
  logic [AW-1:0]   acc;
  logic [CNTW-1:0] cnt;

  logic [PW-1:0]   pp_sum;
  logic [DW-1:0]   den_sum;
  logic [DW:0]     trial;
  logic            trial_ge;
  logic [QW-1:0]   m_next;
  logic [HW-1:0]   prod_hi;
  logic            inexact;
  logic [EW-1:0]   delta;

  assign pp_sum  = PW'(cov) + PW'(process_noise);
  assign den_sum = DW'(pp_sum) + DW'(measure_noise);

  // remainder starts at r >> 1, r[0] is the only numerator bit shifted in
  assign trial    = {rem, (cnt == '0) ? measure_noise[0] : 1'b0};
  assign trial_ge = trial >= {1'b0, den};

  // ceiling of the quotient; zero denominator means no gain
  assign m_next = (den == '0) ? ONE : quo + QW'(rem != '0);

  assign prod_hi = acc[AW-1:CF];
  assign inexact = |acc[CF-1:0];
  assign delta   = prod_hi[EW-1:0];

  assign status.div_last = (cnt == CNTW'(QW - 1));
  assign status.mul_last = (cnt == CNTW'(NDIG - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      est <= '0;
      cov <= '0;
    end else begin
      if (cmd.upd_x) begin
        if (x_ge) est <= est + delta;
        else      est <= est - delta - EW'(inexact);
      end
      if (cmd.upd_p) begin
        if (|prod_hi[HW-1:CF]) cov <= '1;
        else                   cov <= prod_hi[CF-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      z   <= {sample, {EST_FRAC{1'b0}}};
      pp  <= pp_sum;
      den <= den_sum;
      rem <= DW'(measure_noise >> 1);
      quo <= '0;
      cnt <= '0;
    end else if (cmd.div_step) begin
      rem <= trial_ge ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
      quo <= {quo[QW-2:0], trial_ge};
      cnt <= cnt + CNTW'(1);
    end else if (cmd.mul_init) begin
      cnt <= '0;
    end else if (cmd.mul_step) begin
      cnt <= cnt + CNTW'(1);
    end

    if (cmd.prep) begin
      mval <= m_next;
      gain <= ONE - m_next;
      x_ge <= z >= est;
      diff <= (z >= est) ? z - est : est - z;
    end

    // msb-first digit multiply, one digit per cycle
    if (cmd.mul_init) begin
      acc <= '0;
      if (cmd.mul_sel == MUL_M_PP) begin
        dig   <= GW'(mval);
        mcand <= MW'(pp);
      end else begin
        dig   <= GW'(gain);
        mcand <= MW'(diff);
      end
    end else if (cmd.mul_step) begin
      acc <= (acc << DIGIT_W) + AW'(mcand * dig[GW-1 -: DIGIT_W]);
      dig <= dig << DIGIT_W;
    end

    if (cmd.out_load) smoothed <= est[EW-1:EST_FRAC];
  end

endmodule

FILE: rtl/core/sks_ctrl.sv
module sks_ctrl
  import sks_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  output logic        m_tvalid,
  input  logic        m_tready,
  input  sks_status_t status,
  output sks_cmd_t    cmd
);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_DIV  = 10'b00_0000_0010,
    ST_PREP = 10'b00_0000_0100,
    ST_MX0  = 10'b00_0000_1000,
    ST_MX   = 10'b00_0001_0000,
    ST_UX   = 10'b00_0010_0000,
    ST_MP   = 10'b00_0100_0000,
    ST_UP   = 10'b00_1000_0000,
    ST_FIN  = 10'b01_0000_0000,
    ST_HOLD = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.mul_sel = MUL_GAIN_DIFF;
    unique case (state) inside
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = ST_MX0;
      end
      ST_MX0: begin
        cmd.mul_init = 1'b1;
        state_next   = ST_MX;
      end
      ST_MX: begin
        cmd.mul_step = 1'b1;
        if (status.mul_last) state_next = ST_UX;
      end
      ST_UX: begin
        // estimate update and start of the covariance multiply share a cycle
        cmd.upd_x    = 1'b1;
        cmd.mul_init = 1'b1;
        cmd.mul_sel  = MUL_M_PP;
        state_next   = ST_MP;
      end
      ST_MP: begin
        cmd.mul_step = 1'b1;
        if (status.mul_last) state_next = ST_UP;
      end
      ST_UP: begin
        cmd.upd_p  = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN, ST_HOLD: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end else begin
          state_next = ST_HOLD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load)  m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

endmodule

FILE: rtl/core/scalar_kalman_smoother.sv
// channel  | role          | payload
// s_*      | sample in     | s_tdata: sample
// m_*      | estimate out  | m_tdata: smoothed
// apb      | config regs   | 0x0 process_noise, 0x4 measure_noise
//
// after a sample is accepted, the first edge where its result can be taken is also
// the first edge where the next sample can be accepted. the restoring divider
// for the gain (one quotient bit per cycle) runs first, then two 8-bit digit
// multiplies. a finished result sits in the output register; the next sample is
// taken while it waits and holds only at the end if m_tready is still low.
// synchronous reset clears estimate and covariance and loads the noise defaults.
module scalar_kalman_smoother
  import sks_pkg::*;
#(
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
  parameter int COV_FRAC_BITS = COV_FRAC_BITS_DEF,
  localparam int TDATA_W      = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [TDATA_W-1:0]    s_tdata,   // sample
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [TDATA_W-1:0]    m_tdata,   // smoothed
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  sks_cmd_t               cmd;
  sks_status_t            status;
  logic [NOISE_W-1:0]     process_noise;
  logic [NOISE_W-1:0]     measure_noise;
  logic [SAMPLE_BITS-1:0] smoothed;

  assign m_tdata = TDATA_W'(smoothed);

  sks_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .process_noise (process_noise),
    .measure_noise (measure_noise)
  );

  sks_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  sks_datapath #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .COV_FRAC_BITS (COV_FRAC_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .process_noise (process_noise),
    .measure_noise (measure_noise),
    .sample        (s_tdata[SAMPLE_BITS-1:0]),
    .smoothed      (smoothed)
  );

endmodule

FILE: rtl/core/sks_checker.sv
module sks_checker
  import sks_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int TDATA_W    = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [TDATA_W-1:0]    m_tdata,
  input logic                  psel,
  input logic                  penable,
  input logic                  pwrite,
  input logic [APB_ADDR_W-1:0] paddr,
  input logic [APB_DATA_W-1:0] pwdata,
  input logic [APB_DATA_W-1:0] prdata,
  input logic                  pready
);

  // a stalled result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // a request starts a multi-cycle update, so the block goes busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready && !$rose(m_tvalid))
    else $error("accepted a second request or showed a result too early");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("reset did not clear the channels");

  // register readback after a write to the same index
  a_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready ##1 psel && !pwrite && (paddr[2] == $past(paddr[2]))
    |-> prdata[NOISE_W-1:0] == $past(pwdata[NOISE_W-1:0]))
    else $error("register readback mismatch");

endmodule

bind scalar_kalman_smoother sks_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_sks_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .psel     (psel),
  .penable  (penable),
  .pwrite   (pwrite),
  .paddr    (paddr),
  .pwdata   (pwdata),
  .prdata   (prdata),
  .pready   (pready)
);
